// File: rtl/core/ecc_pkg.sv
// ----------------------------------------------------------------------------
// ecc_pkg
// Shared types, constants and calendar helpers for the epoch calendar
// converter.
// ----------------------------------------------------------------------------
package ecc_pkg;

  typedef struct packed {
    logic        req_type;
    logic [1:0]  offset_unit;
    logic [31:0] amount;
    logic [6:0]  in_year;
    logic [3:0]  in_month;
    logic [4:0]  in_day;
    logic [4:0]  in_hour;
    logic [5:0]  in_minute;
    logic [5:0]  in_second;
  } ecc_req_t;

  typedef struct packed {
    logic [31:0] epoch_count;
    logic [6:0]  out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [4:0]  out_hour;
    logic [5:0]  out_minute;
    logic [5:0]  out_second;
    logic [2:0]  day_of_week;
    logic        year_out_of_range;
  } ecc_rsp_t;

  // Day count and time of day of one request, between the day split and
  // the date decoder.
  typedef struct packed {
    logic [31:0] secs;
    logic [15:0] quad_days;
    logic [16:0] day_secs;
    logic [2:0]  wday;
  } ecc_split_t;

  typedef enum logic [1:0] {
    UNIT_SECONDS = 2'd0,
    UNIT_MINUTES = 2'd1,
    UNIT_HOURS   = 2'd2
  } ecc_unit_t;

  localparam logic MODE_EPOCH = 1'b1;

  localparam logic [16:0] SECS_PER_DAY = 17'd86400;

  // First day of a month within its year, counted from zero.
  function automatic logic [8:0] month_first(input logic [3:0] idx, input logic leap);
    logic [8:0] base;
    begin
      case (idx)
        4'd0:    base = 9'd0;
        4'd1:    base = 9'd31;
        4'd2:    base = 9'd59;
        4'd3:    base = 9'd90;
        4'd4:    base = 9'd120;
        4'd5:    base = 9'd151;
        4'd6:    base = 9'd181;
        4'd7:    base = 9'd212;
        4'd8:    base = 9'd243;
        4'd9:    base = 9'd273;
        4'd10:   base = 9'd304;
        4'd11:   base = 9'd334;
        default: base = 9'd0;
      endcase
      month_first = base + {8'd0, (leap && (idx >= 4'd2) && (idx <= 4'd11))};
    end
  endfunction

endpackage

// File: rtl/core/ecc_sec_calc.sv
// ----------------------------------------------------------------------------
// ecc_sec_calc
// Three stages: calendar fields to day count and time of day with the scaled
// offset, then day count to seconds, then the offset sum or the epoch input.
// ----------------------------------------------------------------------------
module ecc_sec_calc (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  logic            in_valid,
  input  ecc_pkg::ecc_req_t req,
  output logic            out_valid,
  output logic [31:0]     secs
);
  import ecc_pkg::*;

  logic [6:0]  yr;
  logic        yr_leap;
  logic [7:0]  yr_plus3;
  logic [5:0]  leaps;
  logic [3:0]  mon_idx;
  logic [15:0] days_c;
  logic        date_ok_c;
  logic [16:0] tod_c;
  logic [31:0] off_c;

  logic        v1, mode1, ok1;
  logic [31:0] amount1, off1;
  logic [15:0] days1;
  logic [16:0] tod1;

  logic        v2, mode2;
  logic [31:0] amount2, off2, base2;

  always_comb begin
    yr       = req.in_year;
    // Year 2100 is a century year and not a leap year.
    yr_leap  = (yr[1:0] == 2'd0) && (yr != 7'd100);
    yr_plus3 = {1'b0, yr} + 8'd3;
    leaps    = yr_plus3[7:2] - {5'd0, (yr > 7'd100)};
    mon_idx  = req.in_month - 4'd1;
    date_ok_c = (req.in_month != 4'd0) && (req.in_month <= 4'd12) && (req.in_day != 5'd0);
    days_c = 16'd10957 + 16'(yr) * 16'd365 + {10'd0, leaps}
           + {7'd0, month_first(mon_idx, yr_leap)} + {11'd0, req.in_day} - 16'd1;
    tod_c  = 17'(req.in_hour) * 17'd3600 + 17'(req.in_minute) * 17'd60
           + {11'd0, req.in_second};
    case (ecc_unit_t'(req.offset_unit))
      UNIT_SECONDS: off_c = req.amount;
      UNIT_MINUTES: off_c = req.amount * 32'd60;
      UNIT_HOURS:   off_c = req.amount * 32'd3600;
      default:      off_c = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mode1   <= req.req_type;
      ok1     <= date_ok_c;
      amount1 <= req.amount;
      off1    <= off_c;
      days1   <= days_c;
      tod1    <= tod_c;

      mode2   <= mode1;
      amount2 <= amount1;
      off2    <= off1;
      base2   <= ok1 ? (32'(days1) * 32'(SECS_PER_DAY) + 32'(tod1)) : 32'd0;

      secs    <= (mode2 == MODE_EPOCH) ? amount2 : base2 + off2;
    end
  end

endmodule

// File: rtl/core/ecc_day_split.sv
// ----------------------------------------------------------------------------
// ecc_day_split
// Three stages: seconds to whole days by reciprocal multiply, days back to
// seconds, then the second of the day, the weekday and the day count from
// 1968-01-01 used by the date decoder.
// ----------------------------------------------------------------------------
module ecc_day_split (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_valid,
  input  logic [31:0]       secs_in,
  output logic              out_valid,
  output ecc_pkg::ecc_split_t split
);
  import ecc_pkg::*;

  // floor(x / 675) for x below 2**25; 86400 is 675 * 2**7.
  localparam logic [25:0] DAY_RECIP = 26'd50903317;
  // Day 2100-03-01; from there the count skips the missing Feb 29 of 2100.
  localparam logic [15:0] MAR_2100 = 16'd47541;
  localparam logic [15:0] DAYS_1968_1970 = 16'd731;

  logic [50:0] prod4;
  logic        v4, v5;
  logic [15:0] q4, q5;
  logic [31:0] secs4, secs5, qm5;

  function automatic logic [2:0] mod7(input logic [16:0] x);
    logic [5:0] s1;
    logic [3:0] s2;
    begin
      // 8 is 1 modulo 7, so octal digits can be summed.
      s1 = {3'd0, x[2:0]} + {3'd0, x[5:3]} + {3'd0, x[8:6]} + {3'd0, x[11:9]}
         + {3'd0, x[14:12]} + {4'd0, x[16:15]};
      s2 = {1'b0, s1[2:0]} + {1'b0, s1[5:3]};
      if (s2 >= 4'd7) begin
        s2 = s2 - 4'd7;
      end
      mod7 = s2[2:0];
    end
  endfunction

  assign prod4 = 51'(secs_in[31:7]) * 51'(DAY_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v4 <= in_valid;
      v5 <= v4;
      out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q4    <= prod4[50:35];
      secs4 <= secs_in;

      q5    <= q4;
      secs5 <= secs4;
      qm5   <= 32'(q4) * 32'(SECS_PER_DAY);

      split.secs      <= secs5;
      split.day_secs  <= 17'(secs5 - qm5);
      split.quad_days <= q5 + DAYS_1968_1970 + {15'd0, (q5 >= MAR_2100)};
      split.wday      <= mod7({1'b0, q5} + 17'd4) + 3'd1;
    end
  end

endmodule

// File: rtl/core/ecc_date_dec.sv
// ----------------------------------------------------------------------------
// ecc_date_dec
// Four stages: leap cycle and hour by reciprocal multiply, remainders, year
// within the cycle and minute, then month, day and second into the result.
// ----------------------------------------------------------------------------
module ecc_date_dec (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_valid,
  input  ecc_pkg::ecc_split_t split,
  output logic              out_valid,
  output ecc_pkg::ecc_rsp_t rsp
);
  import ecc_pkg::*;

  localparam logic [16:0] QUAD_RECIP = 17'd91868;   // floor(x / 1461), shift 27
  localparam logic [17:0] HOUR_RECIP = 18'd149131;  // floor(x / 3600), shift 29
  localparam logic [12:0] MIN_RECIP  = 13'd4370;    // floor(x / 60), shift 18
  localparam logic [7:0]  YEAR_FIRST = 8'd32;       // 2000 counted from 1968
  localparam logic [7:0]  YEAR_LAST  = 8'd131;      // 2099 counted from 1968

  logic [32:0] prod_c;
  logic [34:0] prod_h;
  logic        v7, v8, v9;

  logic [5:0]  c7, c8;
  logic [4:0]  h7, h8, h9;
  logic [15:0] d7;
  logic [16:0] rem7;
  logic [2:0]  wd7, wd8, wd9;
  logic [31:0] secs7, secs8, secs9;

  logic [10:0] r8;
  logic [11:0] mrem8, mrem9;

  logic [1:0]  k_c;
  logic [8:0]  doy_c;
  logic [23:0] prod_m;
  logic [8:0]  doy9;
  logic        leap9;
  logic [7:0]  yo9;
  logic [5:0]  mi9;

  logic [3:0]  mon_c;
  logic [8:0]  start_c;
  logic [8:0]  first_c;

  assign prod_c = 33'(split.quad_days) * 33'(QUAD_RECIP);
  assign prod_h = 35'(split.day_secs) * 35'(HOUR_RECIP);
  assign prod_m = 24'(mrem8) * 24'(MIN_RECIP);

  // Year within the four-year cycle that starts on a leap year.
  always_comb begin
    if (r8 < 11'd366) begin
      k_c   = 2'd0;
      doy_c = r8[8:0];
    end else if (r8 < 11'd731) begin
      k_c   = 2'd1;
      doy_c = 9'(r8 - 11'd366);
    end else if (r8 < 11'd1096) begin
      k_c   = 2'd2;
      doy_c = 9'(r8 - 11'd731);
    end else begin
      k_c   = 2'd3;
      doy_c = 9'(r8 - 11'd1096);
    end
  end

  always_comb begin
    mon_c   = 4'd0;
    start_c = 9'd0;
    for (int i = 1; i < 12; i++) begin
      first_c = month_first(4'(i), leap9);
      if (doy9 >= first_c) begin
        mon_c   = 4'(i);
        start_c = first_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
      v8 <= 1'b0;
      v9 <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v7 <= in_valid;
      v8 <= v7;
      v9 <= v8;
      out_valid <= v9;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c7    <= prod_c[32:27];
      h7    <= prod_h[33:29];
      d7    <= split.quad_days;
      rem7  <= split.day_secs;
      wd7   <= split.wday;
      secs7 <= split.secs;

      r8    <= 11'(d7 - 16'(c7) * 16'd1461);
      mrem8 <= 12'(rem7 - 17'(h7) * 17'd3600);
      c8    <= c7;
      h8    <= h7;
      wd8   <= wd7;
      secs8 <= secs7;

      doy9  <= doy_c;
      leap9 <= (k_c == 2'd0);
      yo9   <= {c8, 2'b00} + {6'd0, k_c};
      mi9   <= prod_m[23:18];
      mrem9 <= mrem8;
      h9    <= h8;
      wd9   <= wd8;
      secs9 <= secs8;

      rsp.epoch_count <= secs9;
      if ((yo9 < YEAR_FIRST) || (yo9 > YEAR_LAST)) begin
        rsp.out_year          <= 7'd0;
        rsp.year_out_of_range <= 1'b1;
      end else begin
        rsp.out_year          <= 7'(yo9 - YEAR_FIRST);
        rsp.year_out_of_range <= 1'b0;
      end
      rsp.out_month   <= mon_c + 4'd1;
      rsp.out_day     <= 5'(doy9 - start_c + 9'd1);
      rsp.out_hour    <= h9;
      rsp.out_minute  <= mi9;
      rsp.out_second  <= 6'(mrem9 - 12'(mi9) * 12'd60);
      rsp.day_of_week <= wd9;
    end
  end

endmodule

// File: rtl/core/epoch_calendar_converter.sv
// ----------------------------------------------------------------------------
// epoch_calendar_converter
// Calendar date-time plus offset, or epoch seconds, to epoch seconds with
// the calendar date-time and weekday of that count.
//
//   channel  direction  handshake           payload
//   req      in         req_valid/req_stall ecc_req_t
//   rsp      out        rsp_valid/rsp_stall ecc_rsp_t
//
// A ten-stage pipeline: three stages form the seconds count, three split it
// into days and second of the day, four decode year, month, day and time.
// One request enters per cycle while req_stall is low.
// Reset clears the valid bit of every stage. While a result waits under
// rsp_stall the whole pipeline holds and req_stall is raised.
// ----------------------------------------------------------------------------
module epoch_calendar_converter (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  ecc_pkg::ecc_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output ecc_pkg::ecc_rsp_t rsp
);
  import ecc_pkg::*;

  logic       adv;
  logic       secs_valid;
  logic [31:0] secs;
  logic       split_valid;
  ecc_split_t split;

  assign adv       = !rsp_valid || !rsp_stall;
  assign req_stall = !adv;

  ecc_sec_calc u_sec_calc (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (req_valid),
    .req       (req),
    .out_valid (secs_valid),
    .secs      (secs)
  );

  ecc_day_split u_day_split (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (secs_valid),
    .secs_in   (secs),
    .out_valid (split_valid),
    .split     (split)
  );

  ecc_date_dec u_date_dec (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (split_valid),
    .split     (split),
    .out_valid (rsp_valid),
    .rsp       (rsp)
  );

endmodule

// File: tb/sv/epoch_calendar_converter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// epoch_calendar_converter_tb
// Self-checking bench for the epoch calendar converter. Requests are sent
// over the valid/stall channel and each one is converted here to the date
// and epoch count that it must give. Returned results are then compared
// field by field in order. A directed set covers the calendar edges and the
// odd inputs, then random traffic runs under three idling patterns.
// ----------------------------------------------------------------------------
module epoch_calendar_converter_tb;
  import ecc_pkg::*;

  localparam logic MODE_CALENDAR = ~MODE_EPOCH;
  localparam int   QUIET_LIMIT   = 2000;
  localparam int   TAIL_CYCLES   = 20;
  localparam int   PHASE_ITEMS   = 545;

  // Keeps the dates still owed by the block, oldest first.
  class date_ledger;
    localparam int unsigned EPOCH_YEAR = 1970;
    localparam int unsigned BASE_YEAR  = 2000;
    localparam int unsigned DAY_SECS   = 86400;
    localparam int unsigned HOUR_SECS  = 3600;

    ecc_pkg::ecc_rsp_t dates_due[$];
    int                errors;

    function new();
      errors = 0;
    endfunction

    function bit leap_year(int unsigned y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function int unsigned leaps_up_to(int unsigned y);
      return y / 4 - y / 100 + y / 400;
    endfunction

    function int unsigned days_before_month(int unsigned m, bit leap);
      int unsigned n;
      case (m)
        0:       n = 0;
        1:       n = 31;
        2:       n = 59;
        3:       n = 90;
        4:       n = 120;
        5:       n = 151;
        6:       n = 181;
        7:       n = 212;
        8:       n = 243;
        9:       n = 273;
        10:      n = 304;
        default: n = 334;
      endcase
      return n + ((leap && m >= 2) ? 1 : 0);
    endfunction

    function logic [31:0] date_seconds(ecc_pkg::ecc_req_t r);
      int unsigned     y;
      int unsigned     m;
      int unsigned     d;
      longint unsigned days;
      longint unsigned secs;
      y = BASE_YEAR + r.in_year;
      m = r.in_month;
      d = r.in_day;
      // A missing month or day stands for the epoch itself.
      if (m == 0 || m > 12 || d == 0) return 32'd0;
      days = longint'((y - EPOCH_YEAR) * 365) + leaps_up_to(y - 1)
           - leaps_up_to(EPOCH_YEAR - 1);
      days += days_before_month(m - 1, leap_year(y) && m > 2) ;
      days += d - 1;
      secs = days * DAY_SECS + longint'(r.in_hour) * HOUR_SECS
           + longint'(r.in_minute) * 60 + longint'(r.in_second);
      return secs[31:0];
    endfunction

    function ecc_pkg::ecc_rsp_t convert(ecc_pkg::ecc_req_t r);
      logic [31:0]       secs;
      logic [31:0]       shift;
      int unsigned       days;
      int unsigned       rem;
      int unsigned       y;
      int unsigned       len;
      int unsigned       m;
      int unsigned       start;
      bit                leap;
      ecc_pkg::ecc_rsp_t e;
      if (r.req_type == ecc_pkg::MODE_EPOCH) begin
        secs = r.amount;
      end else begin
        case (r.offset_unit)
          ecc_pkg::UNIT_SECONDS: shift = r.amount;
          ecc_pkg::UNIT_MINUTES: shift = r.amount * 32'd60;
          ecc_pkg::UNIT_HOURS:   shift = r.amount * 32'd3600;
          default:               shift = 32'd0;
        endcase
        secs = date_seconds(r) + shift;
      end
      days = secs / DAY_SECS;
      rem  = secs % DAY_SECS;
      y = EPOCH_YEAR;
      forever begin
        len = leap_year(y) ? 366 : 365;
        if (days < len) break;
        days -= len;
        y++;
      end
      leap = leap_year(y);
      m = 11;
      forever begin
        start = days_before_month(m, leap);
        if (days >= start || m == 0) break;
        m--;
      end
      e.epoch_count = secs;
      if (y < BASE_YEAR || y > BASE_YEAR + 99) begin
        e.out_year          = '0;
        e.year_out_of_range = 1'b1;
      end else begin
        e.out_year          = 7'(y - BASE_YEAR);
        e.year_out_of_range = 1'b0;
      end
      e.out_month   = 4'(m + 1);
      e.out_day     = 5'(days - start + 1);
      e.out_hour    = 5'(rem / HOUR_SECS);
      e.out_minute  = 6'((rem % HOUR_SECS) / 60);
      e.out_second  = 6'(rem % 60);
      e.day_of_week = 3'((secs / DAY_SECS + 4) % 7 + 1);
      return e;
    endfunction

    function void log_request(ecc_pkg::ecc_req_t r);
      dates_due.push_back(convert(r));
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void match_result(ecc_pkg::ecc_rsp_t got);
      ecc_pkg::ecc_rsp_t want;
      if (dates_due.size() == 0) begin
        errors++;
        $display("%0t: result with no request pending, expected none, got %h",
                 $time, got);
        return;
      end
      want = dates_due.pop_front();
      compare("epoch_count", want.epoch_count, got.epoch_count);
      compare("out_year", 32'(want.out_year), 32'(got.out_year));
      compare("out_month", 32'(want.out_month), 32'(got.out_month));
      compare("out_day", 32'(want.out_day), 32'(got.out_day));
      compare("out_hour", 32'(want.out_hour), 32'(got.out_hour));
      compare("out_minute", 32'(want.out_minute), 32'(got.out_minute));
      compare("out_second", 32'(want.out_second), 32'(got.out_second));
      compare("day_of_week", 32'(want.day_of_week), 32'(got.day_of_week));
      compare("year_out_of_range", 32'(want.year_out_of_range),
              32'(got.year_out_of_range));
    endfunction

    function int pending();
      return dates_due.size();
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  ecc_req_t  req       = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  ecc_rsp_t  rsp;

  int        send_idle_pct = 27;
  int        recv_idle_pct = 64;
  date_ledger ledger;

  epoch_calendar_converter uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) ledger.log_request(req);
      if (rsp_valid && !rsp_stall) ledger.match_result(rsp);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
      else quiet++;
    end
    $display("FAIL epoch_calendar_converter");
    $finish;
  end

  function automatic ecc_req_t date_request(logic mode, logic [1:0] unit,
                                            logic [31:0] amount, int y, int mo,
                                            int d, int h, int mi, int s);
    ecc_req_t r;
    r.req_type    = mode;
    r.offset_unit = unit;
    r.amount      = amount;
    r.in_year     = 7'(y);
    r.in_month    = 4'(mo);
    r.in_day      = 5'(d);
    r.in_hour     = 5'(h);
    r.in_minute   = 6'(mi);
    r.in_second   = 6'(s);
    return r;
  endfunction

  function automatic ecc_req_t random_request();
    logic [95:0] noise;
    ecc_req_t    r;
    int          pick;
    noise = {$urandom, $urandom, $urandom};
    r     = noise[$bits(ecc_req_t)-1:0];
    pick  = $urandom_range(99);
    if (pick < 15) begin
      r.req_type = MODE_EPOCH;
      if ($urandom_range(1) == 1) r.amount = $urandom_range(32'd4102444799, 32'd946684800);
    end else if (pick < 80) begin
      // Plausible dates, mostly with a modest offset.
      r.req_type    = MODE_CALENDAR;
      r.offset_unit = 2'($urandom_range(2));
      r.amount      = ($urandom_range(7) == 0) ? $urandom : $urandom_range(200000);
      r.in_year     = 7'($urandom_range(99));
      r.in_month    = 4'($urandom_range(12, 1));
      r.in_day      = 5'($urandom_range(31, 1));
      r.in_hour     = 5'($urandom_range(23));
      r.in_minute   = 6'($urandom_range(59));
      r.in_second   = 6'($urandom_range(59));
    end
    return r;
  endfunction

  task automatic send_request(input ecc_req_t r);
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic hold_until_drained();
    req_valid <= 1'b0;
    do @(posedge clk); while (ledger.pending() != 0);
  endtask

  task automatic random_phase(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (PHASE_ITEMS) begin
      send_request(random_request());
      if ($urandom_range(199) == 0) hold_until_drained();
    end
    hold_until_drained();
  endtask

  initial begin
    ledger = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Calendar edges and the inputs that take the unusual paths.
    send_request(date_request(MODE_CALENDAR, UNIT_SECONDS, 0, 0, 1, 1, 0, 0, 0));
    send_request(date_request(MODE_CALENDAR, UNIT_SECONDS, 0, 99, 12, 31, 23, 59, 59));
    send_request(date_request(MODE_CALENDAR, UNIT_MINUTES, 90, 24, 2, 29, 12, 34, 56));
    send_request(date_request(MODE_CALENDAR, UNIT_SECONDS, 0, 0, 3, 1, 0, 0, 0));
    send_request(date_request(MODE_CALENDAR, UNIT_HOURS, 1, 0, 2, 29, 23, 0, 0));
    send_request(date_request(MODE_CALENDAR, UNIT_SECONDS, 5, 10, 0, 15, 1, 2, 3));
    send_request(date_request(MODE_CALENDAR, UNIT_SECONDS, 0, 10, 13, 15, 1, 2, 3));
    send_request(date_request(MODE_CALENDAR, UNIT_MINUTES, 7, 10, 15, 31, 31, 63, 63));
    send_request(date_request(MODE_CALENDAR, UNIT_SECONDS, 0, 10, 6, 0, 1, 2, 3));
    send_request(date_request(MODE_CALENDAR, UNIT_SECONDS, 0, 23, 2, 31, 0, 0, 0));
    send_request(date_request(MODE_CALENDAR, UNIT_SECONDS, 0, 23, 4, 31, 0, 0, 0));
    send_request(date_request(MODE_CALENDAR, UNIT_SECONDS, 0, 50, 7, 4, 31, 63, 63));
    send_request(date_request(MODE_CALENDAR, UNIT_SECONDS, 0, 127, 12, 31, 31, 63, 63));
    send_request(date_request(MODE_CALENDAR, UNIT_SECONDS, 0, 100, 1, 1, 0, 0, 0));
    send_request(date_request(MODE_CALENDAR, UNIT_SECONDS, 32'hFFFF_FFFF, 0, 1, 1, 0, 0, 0));
    send_request(date_request(MODE_CALENDAR, UNIT_SECONDS, 32'hFFFF_FFFF, 50, 6, 15, 8, 0, 0));
    send_request(date_request(MODE_CALENDAR, UNIT_MINUTES, 32'hFFFF_FFFF, 50, 6, 15, 8, 0, 0));
    send_request(date_request(MODE_CALENDAR, UNIT_HOURS, 32'hFFFF_FFFF, 50, 6, 15, 8, 0, 0));
    send_request(date_request(MODE_CALENDAR, 2'd3, 12345, 50, 6, 15, 8, 0, 0));
    send_request(date_request(MODE_EPOCH, 2'd3, 0, 127, 15, 31, 31, 63, 63));
    send_request(date_request(MODE_EPOCH, UNIT_HOURS, 32'hFFFF_FFFF, 5, 5, 5, 5, 5, 5));
    send_request(date_request(MODE_EPOCH, UNIT_SECONDS, 32'd946684799, 0, 0, 0, 0, 0, 0));
    send_request(date_request(MODE_EPOCH, UNIT_SECONDS, 32'd946684800, 0, 0, 0, 0, 0, 0));
    send_request(date_request(MODE_EPOCH, UNIT_SECONDS, 32'd4102444799, 0, 0, 0, 0, 0, 0));
    send_request(date_request(MODE_EPOCH, UNIT_SECONDS, 32'd4102444800, 0, 0, 0, 0, 0, 0));

    random_phase(27, 64);
    random_phase(64, 27);
    random_phase(0, 0);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (ledger.errors == 0 && ledger.pending() == 0) begin
      $display("PASS epoch_calendar_converter");
    end else begin
      $display("FAIL epoch_calendar_converter");
    end
    $finish;
  end

endmodule
